// ===== rtl/lnsc_pkg.sv =====
// Shared types, register offsets and divider period function for the noise channel.
package lnsc_pkg;

    localparam int DIVIDER_BITS = 24;
    localparam int PERIOD_W     = 25;
    localparam int WIDE_W       = PERIOD_W + DIVIDER_BITS;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_STEP  = 2'd2,
        KIND_CLOCK = 2'd3
    } kind_t;

    localparam logic [7:0] ADDR_LEN_ENV_LO = 8'h78;
    localparam logic [7:0] ADDR_LEN_ENV_HI = 8'h79;
    localparam logic [7:0] ADDR_FREQ_LO    = 8'h7C;
    localparam logic [7:0] ADDR_FREQ_HI    = 8'h7D;

    localparam logic [14:0] SEED_SHORT = 15'h0040;
    localparam logic [14:0] SEED_LONG  = 15'h4000;
    localparam logic [14:0] TAPS_SHORT = 15'h0060;
    localparam logic [14:0] TAPS_LONG  = 15'h6000;
    localparam logic [7:0]  FREQ_HI_READ_MASK = 8'h40;
    localparam logic [3:0]  VOLUME_MAX = 4'd15;

    typedef logic [DIVIDER_BITS-1:0] divider_t;

    // (r == 0 ? 16 : r * 32) << (s + 1), saturated to the divider width
    function automatic divider_t div_period(input logic [7:0] freq_lo);
        logic [8:0]        base;
        logic [PERIOD_W-1:0] shifted;
        logic [WIDE_W-1:0]   wide;
        logic [WIDE_W-1:0]   lim;
        base    = (freq_lo[3:0] == 4'd0) ? 9'd16 : {freq_lo[3:0], 5'd0};
        shifted = PERIOD_W'(base) << ({1'b0, freq_lo[7:4]} + 5'd1);
        wide    = WIDE_W'(shifted);
        lim     = WIDE_W'({DIVIDER_BITS{1'b1}});
        if (wide > lim)
        begin
            return {DIVIDER_BITS{1'b1}};
        end
        return DIVIDER_BITS'(wide);
    endfunction

endpackage

// ===== rtl/lnsc_in_if.sv =====
// Input channel: one event word (write, read, sequencer step or clock cycle).
interface lnsc_in_if;
    logic                 valid;
    logic                 ready;
    lnsc_pkg::kind_t      kind;
    logic [7:0]           address;
    logic [7:0]           write_data;

    modport source (output valid, output kind, output address, output write_data,
                    input ready);
    modport sink   (input valid, input kind, input address, input write_data,
                    output ready);
endinterface

// ===== rtl/lnsc_out_if.sv =====
// Result channel: read data, channel amplitude and enable status.
interface lnsc_out_if;
    logic              valid;
    logic              ready;
    logic [7:0]        read_data;
    logic signed [4:0] amplitude;
    logic              channel_on;

    modport source (output valid, output read_data, output amplitude,
                    output channel_on, input ready);
    modport sink   (input valid, input read_data, input amplitude,
                    input channel_on, output ready);
endinterface

// ===== rtl/lfsr_noise_sound_channel.sv =====
// Noise sound channel top level: control registers, counters, LFSR and divider.
//
//   channel  | dir | word
//   ---------+-----+-----------------------------------------
//   item     | in  | kind, address, write_data
//   result   | out | read_data, amplitude, channel_on
//
// One word in, one word out; a new word is taken every cycle unless a result stall holds item.ready low.
// Each word updates the state in the cycle it is accepted; its result
// sits in the output register from the next cycle on.
// item.ready falls only while a result waits and result.ready is low.
// Reset (rst_n low, asynchronous) clears all state except the result data registers; no clearing pass.
module lfsr_noise_sound_channel (
    input  logic          clk,
    input  logic          rst_n,
    lnsc_in_if.sink       item,
    lnsc_out_if.source    result
);

    logic [15:0]            len_env_reg, len_env_next;
    logic [15:0]            freq_reg, freq_next;
    logic                   active_reg, active_next;
    logic [3:0]             volume_reg, volume_next;
    logic [6:0]             env_count_reg, env_count_next;
    logic [7:0]             len_count_reg, len_count_next;
    logic [14:0]            shift_reg, shift_next;
    logic                   out_bit_reg, out_bit_next;
    lnsc_pkg::divider_t     divider_reg, divider_next;

    logic                   res_valid_reg;
    logic [7:0]             read_data_reg, read_data_next;
    logic signed [4:0]      amplitude_reg, amplitude_next;
    logic                   channel_on_reg;

    logic                   accept;
    logic                   restart;
    logic [2:0]             env_period;

    assign accept  = item.valid && item.ready;
    assign item.ready = !res_valid_reg || result.ready;
    assign restart = accept && (item.kind == lnsc_pkg::KIND_WRITE)
                     && (item.address == lnsc_pkg::ADDR_FREQ_HI) && item.write_data[7];
    assign env_period = len_env_reg[10:8];

    always_comb
    begin
        len_env_next   = len_env_reg;
        freq_next      = freq_reg;
        active_next    = active_reg;
        volume_next    = volume_reg;
        env_count_next = env_count_reg;
        len_count_next = len_count_reg;
        shift_next     = shift_reg;
        out_bit_next   = out_bit_reg;
        divider_next   = divider_reg;
        read_data_next = 8'd0;
        if (accept)
        begin
            unique case (item.kind)
                lnsc_pkg::KIND_WRITE:
                begin
                    unique case (item.address)
                        lnsc_pkg::ADDR_LEN_ENV_LO: len_env_next[7:0]  = item.write_data;
                        lnsc_pkg::ADDR_LEN_ENV_HI: len_env_next[15:8] = item.write_data;
                        lnsc_pkg::ADDR_FREQ_LO:    freq_next[7:0]     = item.write_data;
                        lnsc_pkg::ADDR_FREQ_HI:
                        begin
                            freq_next[15:8] = item.write_data;
                            if (item.write_data[7])
                            begin
                                active_next    = 1'b1;
                                len_count_next = {1'b0, 7'd64 - {1'b0, len_env_reg[5:0]}}
                                                 << 1;
                                volume_next    = len_env_reg[15:12];
                                env_count_next = {1'b0, env_period, 3'd0};
                                shift_next     = freq_reg[3] ? lnsc_pkg::SEED_SHORT
                                                             : lnsc_pkg::SEED_LONG;
                                divider_next   = lnsc_pkg::div_period(freq_reg[7:0]);
                            end
                        end
                        default: ;
                    endcase
                end
                lnsc_pkg::KIND_READ:
                begin
                    unique case (item.address)
                        lnsc_pkg::ADDR_LEN_ENV_HI: read_data_next = len_env_reg[15:8];
                        lnsc_pkg::ADDR_FREQ_LO:    read_data_next = freq_reg[7:0];
                        lnsc_pkg::ADDR_FREQ_HI:
                            read_data_next = freq_reg[15:8] & lnsc_pkg::FREQ_HI_READ_MASK;
                        default:                   read_data_next = 8'd0;
                    endcase
                end
                lnsc_pkg::KIND_STEP:
                begin
                    if (freq_reg[14] && (len_count_reg != 8'd0))
                    begin
                        len_count_next = len_count_reg - 8'd1;
                        if (len_count_reg == 8'd1)
                        begin
                            active_next = 1'b0;
                        end
                    end
                    if (env_count_reg != 7'd0)
                    begin
                        if (env_count_reg == 7'd1)
                        begin
                            env_count_next = (env_period == 3'd0) ? 7'd64
                                                                  : {1'b0, env_period, 3'd0};
                            if (len_env_reg[11])
                            begin
                                if (volume_reg != lnsc_pkg::VOLUME_MAX)
                                begin
                                    volume_next = volume_reg + 4'd1;
                                end
                            end
                            else if (volume_reg != 4'd0)
                            begin
                                volume_next = volume_reg - 4'd1;
                            end
                        end
                        else
                        begin
                            env_count_next = env_count_reg - 7'd1;
                        end
                    end
                end
                lnsc_pkg::KIND_CLOCK:
                begin
                    if (divider_reg != '0)
                    begin
                        if (divider_reg == lnsc_pkg::divider_t'(1))
                        begin
                            out_bit_next = shift_reg[0];
                            shift_next   = (shift_reg >> 1)
                                           ^ (shift_reg[0] ? (freq_reg[3]
                                                ? lnsc_pkg::TAPS_SHORT
                                                : lnsc_pkg::TAPS_LONG) : 15'd0);
                            divider_next = lnsc_pkg::div_period(freq_reg[7:0]);
                        end
                        else
                        begin
                            divider_next = divider_reg - lnsc_pkg::divider_t'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
        if (active_next && (len_env_next[15:11] != 5'd0))
        begin
            amplitude_next = out_bit_next ? $signed({1'b0, volume_next})
                                          : -$signed({1'b0, volume_next});
        end
        else
        begin
            amplitude_next = 5'sd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_env_reg    <= '0;
            freq_reg       <= '0;
            active_reg     <= 1'b0;
            volume_reg     <= '0;
            env_count_reg  <= '0;
            len_count_reg  <= '0;
            shift_reg      <= '0;
            out_bit_reg    <= 1'b0;
            divider_reg    <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            len_env_reg    <= len_env_next;
            freq_reg       <= freq_next;
            active_reg     <= active_next;
            volume_reg     <= volume_next;
            env_count_reg  <= env_count_next;
            len_count_reg  <= len_count_next;
            shift_reg      <= shift_next;
            out_bit_reg    <= out_bit_next;
            divider_reg    <= divider_next;
            if (item.ready)
            begin
                res_valid_reg <= accept;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_data_reg  <= read_data_next;
            amplitude_reg  <= amplitude_next;
            channel_on_reg <= active_next;
        end
    end

    assign result.valid      = res_valid_reg;
    assign result.read_data  = read_data_reg;
    assign result.amplitude  = amplitude_reg;
    assign result.channel_on = channel_on_reg;

    a_amp_needs_on: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && (result.amplitude != 5'sd0) |-> result.channel_on)
        else $error("nonzero amplitude on a disabled channel");

    a_divider_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (divider_reg == '0) && !restart |=> (divider_reg == '0))
        else $error("divider started without a restart");

    a_off_stays_off: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg && !restart |=> !active_reg)
        else $error("channel enabled without a restart");

endmodule

// ===== tb/tb_lfsr_noise_sound_channel.sv =====
// Self-checking testbench for the noise sound channel: directed and random words, LFSR mirror.
module tb_lfsr_noise_sound_channel;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 400;
    localparam int SOAK_WORDS   = 600;
    localparam int CYCLE_LIMIT  = 1500000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [7:0]        read_data;
        logic signed [4:0] amplitude;
        logic              channel_on;
    } channel_out_t;

    class channel_mirror;
        logic [15:0]        len_env;
        logic [15:0]        freq;
        logic               on;
        logic [3:0]         vol;
        logic [6:0]         env_cnt;
        logic [7:0]         len_cnt;
        logic [14:0]        lfsr;
        logic               out_bit;
        lnsc_pkg::divider_t div_cnt;
        channel_out_t       expected_outputs[$];
        int                 mismatch_count;
        int                 checked;

        function new();
            len_env        = '0;
            freq           = '0;
            on             = 1'b0;
            vol            = '0;
            env_cnt        = '0;
            len_cnt        = '0;
            lfsr           = '0;
            out_bit        = 1'b0;
            div_cnt        = '0;
            mismatch_count = 0;
            checked        = 0;
        endfunction

        function lnsc_pkg::divider_t period_of(logic [7:0] flo);
            logic [63:0] p;
            p = (flo[3:0] == 4'd0) ? 64'd16 : 64'(flo[3:0]) * 64'd32;
            p = p << (int'(flo[7:4]) + 1);
            if (p > 64'((64'd1 << lnsc_pkg::DIVIDER_BITS) - 64'd1))
            begin
                return {lnsc_pkg::DIVIDER_BITS{1'b1}};
            end
            return p[lnsc_pkg::DIVIDER_BITS-1:0];
        endfunction

        function void restart();
            on      = 1'b1;
            len_cnt = 8'((64 - int'(len_env[5:0])) * 2);
            vol     = len_env[15:12];
            env_cnt = 7'({len_env[10:8], 3'b000});
            lfsr    = freq[3] ? lnsc_pkg::SEED_SHORT : lnsc_pkg::SEED_LONG;
            div_cnt = period_of(freq[7:0]);
        endfunction

        function void frame_step();
            logic [2:0] per;
            per = len_env[10:8];
            if (freq[14] && len_cnt != 8'd0)
            begin
                len_cnt = len_cnt - 8'd1;
                if (len_cnt == 8'd0)
                begin
                    on = 1'b0;
                end
            end
            if (env_cnt != 7'd0)
            begin
                env_cnt = env_cnt - 7'd1;
                if (env_cnt == 7'd0)
                begin
                    env_cnt = (per == 3'd0) ? 7'd64 : 7'({per, 3'b000});
                    if (len_env[11])
                    begin
                        if (vol != lnsc_pkg::VOLUME_MAX)
                        begin
                            vol = vol + 4'd1;
                        end
                    end
                    else if (vol != 4'd0)
                    begin
                        vol = vol - 4'd1;
                    end
                end
            end
        endfunction

        function void clock_tick();
            if (div_cnt == '0)
            begin
                return;
            end
            div_cnt = div_cnt - 1'b1;
            if (div_cnt == '0)
            begin
                out_bit = lfsr[0];
                lfsr    = lfsr >> 1;
                if (out_bit)
                begin
                    lfsr = lfsr ^ (freq[3] ? lnsc_pkg::TAPS_SHORT : lnsc_pkg::TAPS_LONG);
                end
                div_cnt = period_of(freq[7:0]);
            end
        endfunction

        function void take_word(lnsc_pkg::kind_t k, logic [7:0] addr, logic [7:0] data);
            channel_out_t      want;
            logic signed [4:0] mag;
            want = '0;
            case (k)
                lnsc_pkg::KIND_WRITE:
                begin
                    case (addr)
                        lnsc_pkg::ADDR_LEN_ENV_LO: len_env[7:0]  = data;
                        lnsc_pkg::ADDR_LEN_ENV_HI: len_env[15:8] = data;
                        lnsc_pkg::ADDR_FREQ_LO:    freq[7:0]     = data;
                        lnsc_pkg::ADDR_FREQ_HI:
                        begin
                            freq[15:8] = data;
                            if (data[7])
                            begin
                                restart();
                            end
                        end
                        default: ;
                    endcase
                end
                lnsc_pkg::KIND_READ:
                begin
                    case (addr)
                        lnsc_pkg::ADDR_LEN_ENV_HI: want.read_data = len_env[15:8];
                        lnsc_pkg::ADDR_FREQ_LO:    want.read_data = freq[7:0];
                        lnsc_pkg::ADDR_FREQ_HI:
                            want.read_data = freq[15:8] & lnsc_pkg::FREQ_HI_READ_MASK;
                        default:                   want.read_data = 8'd0;
                    endcase
                end
                lnsc_pkg::KIND_STEP:  frame_step();
                default:              clock_tick();
            endcase
            mag = {1'b0, vol};
            if (on && len_env[15:11] != 5'd0)
            begin
                want.amplitude = out_bit ? mag : -mag;
            end
            want.channel_on = on;
            expected_outputs.push_back(want);
        endfunction

        task report(string msg);
            if (mismatch_count < 40)
            begin
                $display("MISMATCH result %0d: %s", checked, msg);
            end
            mismatch_count++;
        endtask

        task check_output(logic [7:0] rd, logic signed [4:0] amp, logic chan_on);
            channel_out_t want;
            if (expected_outputs.size() == 0)
            begin
                report($sformatf("unexpected word rd=%02h amp=%0d on=%0b", rd, amp, chan_on));
                return;
            end
            want = expected_outputs.pop_front();
            checked++;
            if (rd !== want.read_data)
            begin
                report($sformatf("read_data %02h, want %02h", rd, want.read_data));
            end
            if (amp !== want.amplitude)
            begin
                report($sformatf("amplitude %0d, want %0d", amp, want.amplitude));
            end
            if (chan_on !== want.channel_on)
            begin
                report($sformatf("channel_on %0b, want %0b", chan_on, want.channel_on));
            end
        endtask

        function int outstanding();
            return expected_outputs.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic quiet = 1'b0;
    int   cycles = 0;
    int   words_sent = 0;

    channel_mirror mirror = new();

    lnsc_in_if  item_if();
    lnsc_out_if result_if();

    lfsr_noise_sound_channel DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_if),
        .result (result_if)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int idle_length();
        int pick;
        if (quiet)
        begin
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 60)
        begin
            return 0;
        end
        if (pick < 90)
        begin
            return $urandom_range(1, 3);
        end
        if (pick < 97)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(11, 40);
    endfunction

    function automatic logic [7:0] mapped_address();
        case ($urandom_range(0, 3))
            0:       return lnsc_pkg::ADDR_LEN_ENV_LO;
            1:       return lnsc_pkg::ADDR_LEN_ENV_HI;
            2:       return lnsc_pkg::ADDR_FREQ_LO;
            default: return lnsc_pkg::ADDR_FREQ_HI;
        endcase
    endfunction

    function automatic logic [7:0] fast_freq_lo();
        logic [3:0] r;
        logic [3:0] s;
        if ($urandom_range(0, 9) == 0)
        begin
            return 8'($urandom);
        end
        r = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 2));
        s = 4'($urandom_range(0, 1));
        return {s, r};
    endfunction

    task automatic send_word(lnsc_pkg::kind_t k, logic [7:0] addr, logic [7:0] data);
        int gap;
        gap = idle_length();
        if (gap > 0)
        begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_if.valid      <= 1'b1;
        item_if.kind       <= k;
        item_if.address    <= addr;
        item_if.write_data <= data;
        do
            @(posedge clk);
        while (!item_if.ready);
        mirror.take_word(k, addr, data);
        words_sent++;
    endtask

    task automatic write_reg(logic [7:0] addr, logic [7:0] data);
        send_word(lnsc_pkg::KIND_WRITE, addr, data);
    endtask

    task automatic read_reg(logic [7:0] addr);
        send_word(lnsc_pkg::KIND_READ, addr, 8'($urandom));
    endtask

    task automatic clocks(int n);
        repeat (n) send_word(lnsc_pkg::KIND_CLOCK, 8'($urandom), 8'($urandom));
    endtask

    task automatic steps(int n);
        repeat (n) send_word(lnsc_pkg::KIND_STEP, 8'($urandom), 8'($urandom));
    endtask

    task automatic hold_until_drained();
        item_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (mirror.outstanding() != 0);
    endtask

    task automatic program_and_restart(logic [7:0] freq_lo);
        write_reg(lnsc_pkg::ADDR_LEN_ENV_LO, 8'($urandom));
        write_reg(lnsc_pkg::ADDR_LEN_ENV_HI, 8'($urandom));
        write_reg(lnsc_pkg::ADDR_FREQ_LO, freq_lo);
        write_reg(lnsc_pkg::ADDR_FREQ_HI, {1'b1, 7'($urandom)});
    endtask

    task automatic busy_run(int run_len, int step_pct);
        int pick;
        repeat (run_len)
        begin
            pick = $urandom_range(0, 99);
            if (pick < step_pct)
            begin
                steps(1);
            end
            else if (pick < step_pct + 8)
            begin
                read_reg(mapped_address());
            end
            else if (pick < step_pct + 11)
            begin
                case ($urandom_range(0, 2))
                    0:       write_reg(lnsc_pkg::ADDR_LEN_ENV_HI, 8'($urandom));
                    1:       write_reg(lnsc_pkg::ADDR_FREQ_LO, fast_freq_lo());
                    default: write_reg(lnsc_pkg::ADDR_FREQ_HI, {1'b0, 7'($urandom)});
                endcase
            end
            else
            begin
                clocks(1);
            end
        end
    endtask

    task automatic noise_run();
        logic [7:0] addr;
        repeat ($urandom_range(5, 20))
        begin
            addr = ($urandom_range(0, 1) == 0) ? mapped_address() : 8'($urandom);
            send_word(lnsc_pkg::kind_t'($urandom_range(0, 3)), addr, 8'($urandom));
        end
    endtask

    initial
    begin
        result_if.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            int stall_left;
            @(posedge clk);
            if (result_if.valid && result_if.ready)
            begin
                mirror.check_output(result_if.read_data, result_if.amplitude,
                                    result_if.channel_on);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_if.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 99) < 30)
            begin
                stall_left = idle_length();
                result_if.ready <= (stall_left == 0);
            end
            else
            begin
                result_if.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        int  seq_count;
        int  stop_at;
        bit  soak_done;
        item_if.valid      <= 1'b0;
        item_if.kind       <= lnsc_pkg::KIND_CLOCK;
        item_if.address    <= 8'd0;
        item_if.write_data <= 8'd0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values, unmapped addresses, stopped divider
        read_reg(lnsc_pkg::ADDR_LEN_ENV_HI);
        read_reg(lnsc_pkg::ADDR_FREQ_LO);
        read_reg(lnsc_pkg::ADDR_FREQ_HI);
        read_reg(8'h00);
        read_reg(8'hFF);
        clocks(2);
        steps(1);
        write_reg(8'hFF, 8'hFF);
        // silent DAC while active, length enabled, read mask on high byte
        write_reg(lnsc_pkg::ADDR_LEN_ENV_LO, 8'hFF);
        write_reg(lnsc_pkg::ADDR_LEN_ENV_HI, 8'h07);
        write_reg(lnsc_pkg::ADDR_FREQ_LO, 8'h00);
        write_reg(lnsc_pkg::ADDR_FREQ_HI, 8'hFF);
        read_reg(lnsc_pkg::ADDR_FREQ_HI);
        read_reg(lnsc_pkg::ADDR_LEN_ENV_HI);
        read_reg(lnsc_pkg::ADDR_FREQ_LO);
        // full volume, length expiry after two steps, LFSR keeps running
        write_reg(lnsc_pkg::ADDR_LEN_ENV_HI, 8'hF8);
        write_reg(lnsc_pkg::ADDR_FREQ_HI, 8'hC0);
        steps(2);
        clocks(34);
        // envelope up with saturation, oversized period
        write_reg(lnsc_pkg::ADDR_LEN_ENV_LO, 8'h00);
        write_reg(lnsc_pkg::ADDR_LEN_ENV_HI, 8'hE9);
        write_reg(lnsc_pkg::ADDR_FREQ_LO, 8'hFF);
        write_reg(lnsc_pkg::ADDR_FREQ_HI, 8'h80);
        steps(17);
        // envelope down to zero
        write_reg(lnsc_pkg::ADDR_LEN_ENV_HI, 8'h11);
        write_reg(lnsc_pkg::ADDR_FREQ_LO, 8'hF0);
        write_reg(lnsc_pkg::ADDR_FREQ_HI, 8'h80);
        steps(17);
        hold_until_drained();

        seq_count = 0;
        soak_done = 0;
        stop_at   = words_sent + RANDOM_WORDS + SOAK_WORDS;
        while (words_sent < stop_at)
        begin
            quiet = ($urandom_range(0, 3) == 0);
            if (!soak_done && seq_count == 0)
            begin
                // short LFSR: slow divider, so hold many clock words
                quiet = 1'b1;
                program_and_restart(8'h08);
                busy_run(SOAK_WORDS, 1);
                soak_done = 1;
            end
            else if ($urandom_range(0, 3) != 0)
            begin
                program_and_restart(fast_freq_lo());
                busy_run(($urandom_range(0, 3) == 0) ? $urandom_range(200, 500)
                                                     : $urandom_range(20, 80),
                         $urandom_range(5, 30));
            end
            else
            begin
                noise_run();
            end
            seq_count++;
            if (seq_count % 4 == 0)
            begin
                hold_until_drained();
            end
        end

        quiet = 1'b0;
        item_if.valid <= 1'b0;
        while (mirror.outstanding() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mirror.mismatch_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
